// ===== hdl/bbr_pkg.sv =====
package bbr_pkg;

  // Defaults for the top-level size parameters
  localparam int MAX_RADIUS_DEF = 10;
  localparam int MAX_WIDTH_DEF  = 1024;

  // Row limit of the clamp on the height register
  localparam int MAX_HEIGHT = 1024;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 11;
  localparam int RAD_W   = 4;
  localparam int N_W     = RAD_W + 1;
  localparam int RCP_W   = 16;
  localparam int CS_W    = 13;
  localparam int WS_W    = 17;
  localparam int PRD_W   = WS_W + RCP_W;
  localparam int CFG_W   = 16;
  localparam int REG_IDX_W = 2;

  // Output queue depth; covers the pipeline latency at full rate
  localparam int OUT_DEPTH = 8;

  // Register reset values
  localparam logic [CNT_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CNT_W-1:0] RST_HEIGHT = 11'd480;
  localparam logic [RAD_W-1:0] RST_RADIUS = 4'd2;
  localparam logic [RCP_W-1:0] RST_RECIP  = 16'd2621;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_RECIP  = 2'd3
  } bbr_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             eol;
    logic             eof;
  } bbr_res_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [N_W-1:0] col_rem;
    logic [N_W-1:0] row_rem;
  } bbr_rem_t;

endpackage

// ===== hdl/bbr_rem.sv =====
module bbr_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bbr_pkg::N_W-1:0]   n_div,
  input  logic [bbr_pkg::CNT_W-1:0] col,
  input  logic [bbr_pkg::CNT_W-1:0] row,
  output bbr_pkg::bbr_rem_t         st
);

  localparam int BIT_W = $clog2(bbr_pkg::CNT_W + 1);
  localparam int POS_W = $clog2(bbr_pkg::CNT_W);

  logic [BIT_W-1:0]        bit_r;
  logic                    done_r;
  logic [bbr_pkg::N_W-1:0] rc_r;
  logic [bbr_pkg::N_W-1:0] rr_r;
  logic [POS_W-1:0]        pos;

  // One restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [bbr_pkg::N_W-1:0] rstep(
    input logic [bbr_pkg::N_W-1:0] rem,
    input logic                    b,
    input logic [bbr_pkg::N_W-1:0] d
  );
    logic [bbr_pkg::N_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[bbr_pkg::N_W-1:0];
  endfunction

  assign pos = POS_W'(bit_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        bit_r <= BIT_W'(bbr_pkg::CNT_W);
        rc_r  <= '0;
        rr_r  <= '0;
      end else if (bit_r != '0) begin
        rc_r   <= rstep(rc_r, col[pos], n_div);
        rr_r   <= rstep(rr_r, row[pos], n_div);
        bit_r  <= bit_r - 1'b1;
        done_r <= (bit_r == BIT_W'(1));
      end
    end
  end

  assign st.busy    = (bit_r != '0) || done_r;
  assign st.done    = done_r;
  assign st.col_rem = rc_r;
  assign st.row_rem = rr_r;

endmodule

// ===== hdl/bbr_fifo.sv =====
module bbr_fifo #(
  parameter int DEPTH = bbr_pkg::OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bbr_pkg::bbr_res_t wdata,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output bbr_pkg::bbr_res_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bbr_pkg::bbr_res_t q_r [DEPTH];
  logic [AW-1:0]     wp_r;
  logic [AW-1:0]     rp_r;
  logic [CW-1:0]     cnt_r;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign rdata     = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

// ===== hdl/box_blur_rgb.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_red, in_green, in_blue, in_is_pad
// out     | output    | out_valid/out_ready| out_red, out_green, out_blue,
//         |           |                    | out_end_of_line, out_end_of_frame
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel transaction per cycle while in_ready is high.
// After reset the line store and column sums are swept to zero, one entry per
// cycle, over (2*MAX_RADIUS+1)*MAX_WIDTH line store addresses (21504 at default sizes).
// A radius write recomputes the row and column slot remainders bit by bit,
// which holds in_ready low until the recomputation finishes.
// A credit count of queued and in-flight results at the queue depth holds
// in_ready low only for transactions that produce a result; the pipeline itself never stalls.
module box_blur_rgb #(
  parameter int MAX_RADIUS = bbr_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = bbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bbr_pkg::PIX_W-1:0]     in_red,
  input  logic [bbr_pkg::PIX_W-1:0]     in_green,
  input  logic [bbr_pkg::PIX_W-1:0]     in_blue,
  input  logic                          in_is_pad,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bbr_pkg::PIX_W-1:0]     out_red,
  output logic [bbr_pkg::PIX_W-1:0]     out_green,
  output logic [bbr_pkg::PIX_W-1:0]     out_blue,
  output logic                          out_end_of_line,
  output logic                          out_end_of_frame,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [bbr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int WIN_MAX  = 2 * MAX_RADIUS + 1;
  localparam int LS_DEPTH = WIN_MAX * MAX_WIDTH;
  localparam int LAW      = $clog2(LS_DEPTH);
  localparam int CAW      = $clog2(MAX_WIDTH);
  localparam int WSW      = $clog2(WIN_MAX);
  localparam int EXT_W    = bbr_pkg::CNT_W + 2;
  localparam int CRD_W    = $clog2(bbr_pkg::OUT_DEPTH + 1);
  localparam int PW       = bbr_pkg::PIX_W;
  localparam int CSW      = bbr_pkg::CS_W;
  localparam int WSUM_W   = bbr_pkg::WS_W;
  localparam int NW       = bbr_pkg::N_W;

  // Per-transaction control that rides along stages B and C
  typedef struct packed {
    logic [NW-1:0] wslot;
    logic          col0;
    logic          ltn;
    logic          prod;
    logic          eol;
    logic          eof;
  } stg_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bbr_pkg::CNT_W-1:0] width_r;
  logic [bbr_pkg::CNT_W-1:0] height_r;
  logic [bbr_pkg::RAD_W-1:0] radius_r;
  logic [bbr_pkg::RCP_W-1:0] recip_r;
  logic                      cfg_acc;
  logic                      rem_start;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign rem_start = cfg_acc && (cfg_index == bbr_pkg::REG_RADIUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbr_pkg::RST_WIDTH;
      height_r <= bbr_pkg::RST_HEIGHT;
      radius_r <= bbr_pkg::RST_RADIUS;
      recip_r  <= bbr_pkg::RST_RECIP;
    end else if (cfg_acc) begin
      case (cfg_index)
        bbr_pkg::REG_WIDTH:  width_r  <= cfg_data[bbr_pkg::CNT_W-1:0];
        bbr_pkg::REG_HEIGHT: height_r <= cfg_data[bbr_pkg::CNT_W-1:0];
        bbr_pkg::REG_RADIUS: radius_r <= cfg_data[bbr_pkg::RAD_W-1:0];
        bbr_pkg::REG_RECIP:  recip_r  <= cfg_data[bbr_pkg::RCP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry: zero width or height acts as one, oversize acts as max
  logic [EXT_W-1:0]          w_e;
  logic [EXT_W-1:0]          h_e;
  logic [bbr_pkg::RAD_W-1:0] r_e;
  logic [NW-1:0]             n_e;
  logic [EXT_W-1:0]          r_x;
  logic [EXT_W-1:0]          n_x;

  assign w_e = (width_r == '0) ? EXT_W'(1) :
               (32'(width_r) > 32'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : EXT_W'(width_r);
  assign h_e = (height_r == '0) ? EXT_W'(1) :
               (32'(height_r) > 32'(bbr_pkg::MAX_HEIGHT)) ? EXT_W'(bbr_pkg::MAX_HEIGHT) :
               EXT_W'(height_r);
  assign r_e = (32'(radius_r) > 32'(MAX_RADIUS)) ? bbr_pkg::RAD_W'(MAX_RADIUS) : radius_r;
  assign n_e = {r_e, 1'b1};
  assign r_x = EXT_W'(r_e);
  assign n_x = EXT_W'(n_e);

  // ---------------------------------------------------------------------------
  // Clearing sweep of both memories after reset
  // ---------------------------------------------------------------------------
  logic [LAW-1:0] clr_r;
  logic           clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == LAW'(LS_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Slot remainders after a radius change
  // ---------------------------------------------------------------------------
  logic [bbr_pkg::CNT_W-1:0] col_r;
  logic [bbr_pkg::CNT_W-1:0] row_r;
  logic [NW-1:0]             slot_r;
  logic [NW-1:0]             wslot_r;
  bbr_pkg::bbr_rem_t         rem_st;

  bbr_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .n_div (n_e),
    .col   (col_r),
    .row   (row_r),
    .st    (rem_st)
  );

  // ---------------------------------------------------------------------------
  // Stage A: position decode, memory read issue, handshake
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0]          col_x;
  logic [EXT_W-1:0]          row_x;
  logic [EXT_W-1:0]          ox;
  logic [EXT_W-1:0]          oy;
  logic                      inside_a;
  logic                      wr_a;
  logic                      prod_a;
  logic                      eol_a;
  logic                      row_end;
  logic                      frame_end;
  logic                      acc;
  logic [CRD_W-1:0]          credit_r;
  logic [CAW-1:0]            ca_a;
  logic [LAW-1:0]            la_a;
  logic [3*PW-1:0]           px_a;
  stg_t                      stg_a;
  logic [bbr_pkg::CNT_W-1:0] col_nxt;
  logic [bbr_pkg::CNT_W-1:0] row_nxt;
  logic [NW-1:0]             slot_inc;
  logic [NW-1:0]             wslot_inc;

  assign col_x     = EXT_W'(col_r);
  assign row_x     = EXT_W'(row_r);
  assign ox        = col_x - r_x;
  assign oy        = row_x - r_x;
  assign wr_a      = (col_x < w_e);
  assign inside_a  = !in_is_pad && wr_a && (row_x < h_e);
  assign prod_a    = (col_x >= r_x) && (row_x >= r_x) && (ox < w_e) && (oy < h_e);
  assign eol_a     = (ox == w_e - 1'b1);
  assign row_end   = (col_x >= w_e + r_x - 1'b1);
  assign frame_end = (row_x >= h_e + r_x - 1'b1);

  assign px_a = inside_a ? {in_blue, in_green, in_red} : '0;
  assign ca_a = CAW'(col_r);
  assign la_a = LAW'(LAW'(slot_r) * LAW'(MAX_WIDTH) + LAW'(col_r));

  assign stg_a.wslot = wslot_r;
  assign stg_a.col0  = (col_r == '0);
  assign stg_a.ltn   = (col_x < n_x);
  assign stg_a.prod  = prod_a;
  assign stg_a.eol   = eol_a;
  assign stg_a.eof   = eol_a && (oy == h_e - 1'b1);

  // Hold off while sweeping, while remainders are recomputed, or when a
  // producing transaction would find no room left in the output queue
  assign in_ready = !clr_busy_r && !rem_st.busy &&
                    (!prod_a || (credit_r < CRD_W'(bbr_pkg::OUT_DEPTH)));
  assign acc      = in_valid && in_ready;

  // Advance raster position and slot counters; a wrap to zero resets the slot
  assign col_nxt   = row_end ? '0 : bbr_pkg::CNT_W'(col_r + 1'b1);
  assign row_nxt   = !row_end ? row_r : frame_end ? '0 : bbr_pkg::CNT_W'(row_r + 1'b1);
  assign wslot_inc = (NW'(wslot_r + 1'b1) == n_e) ? '0 : NW'(wslot_r + 1'b1);
  assign slot_inc  = (NW'(slot_r + 1'b1) == n_e) ? '0 : NW'(slot_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= '0;
      wslot_r <= '0;
    end else if (rem_st.done) begin
      slot_r  <= rem_st.row_rem;
      wslot_r <= rem_st.col_rem;
    end else if (acc) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wslot_r <= (col_nxt == '0) ? '0 : wslot_inc;
      if (row_end) begin
        slot_r <= (row_nxt == '0) ? '0 : slot_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: column sum update, memory write back with forwarding
  // ---------------------------------------------------------------------------
  logic            b_vld_r;
  logic            b_wr_r;
  logic [CAW-1:0]  b_ca_r;
  logic [LAW-1:0]  b_la_r;
  logic            b_row0_r;
  logic            b_rdold_r;
  logic [3*PW-1:0] b_px_r;
  logic            b_fcs_r;
  logic            b_fls_r;
  stg_t            b_stg_r;

  logic [3*CSW-1:0] cs_mem [MAX_WIDTH];
  logic [3*PW-1:0]  ls_mem [LS_DEPTH];
  logic [3*CSW-1:0] cs_rd_r;
  logic [3*PW-1:0]  ls_rd_r;
  logic [3*CSW-1:0] fw_cs_r;
  logic [3*PW-1:0]  fw_px_r;
  logic [3*CSW-1:0] cs_old;
  logic [3*PW-1:0]  ls_old;
  logic [3*CSW-1:0] cs_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_wr_r    <= wr_a;
      b_ca_r    <= ca_a;
      b_la_r    <= la_a;
      b_row0_r  <= (row_r == '0);
      b_rdold_r <= (row_x >= n_x);
      b_px_r    <= px_a;
      // Same entry still being written by the transaction ahead: take its data
      b_fcs_r   <= b_vld_r && b_wr_r && (b_ca_r == ca_a);
      b_fls_r   <= b_vld_r && b_wr_r && (b_la_r == la_a);
      b_stg_r   <= stg_a;
    end
    if (b_vld_r) begin
      fw_cs_r <= cs_b;
      fw_px_r <= b_px_r;
    end
  end

  assign cs_old = b_fcs_r ? fw_cs_r : cs_rd_r;
  assign ls_old = b_fls_r ? fw_px_r : ls_rd_r;

  always_comb begin
    logic [PW-1:0]  old_px;
    logic [CSW-1:0] sum_ch;
    cs_b = '0;
    for (int ch = 0; ch < 3; ch++) begin
      old_px = b_rdold_r ? ls_old[ch*PW +: PW] : '0;
      sum_ch = cs_old[ch*CSW +: CSW] + CSW'(b_px_r[ch*PW +: PW]) - CSW'(old_px);
      if (b_wr_r) begin
        cs_b[ch*CSW +: CSW] = b_row0_r ? CSW'(b_px_r[ch*PW +: PW]) : sum_ch;
      end
    end
  end

  // Single write port per memory: the sweep owns it until it finishes
  logic             cs_we;
  logic [CAW-1:0]   cs_wa;
  logic [3*CSW-1:0] cs_wd;
  logic             ls_we;
  logic [LAW-1:0]   ls_wa;
  logic [3*PW-1:0]  ls_wd;

  assign cs_we = clr_busy_r ? (32'(clr_r) < 32'(MAX_WIDTH)) : (b_vld_r && b_wr_r);
  assign cs_wa = clr_busy_r ? CAW'(clr_r) : b_ca_r;
  assign cs_wd = clr_busy_r ? '0 : cs_b;
  assign ls_we = clr_busy_r || (b_vld_r && b_wr_r);
  assign ls_wa = clr_busy_r ? clr_r : b_la_r;
  assign ls_wd = clr_busy_r ? '0 : b_px_r;

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_wa] <= cs_wd;
    end
    cs_rd_r <= cs_mem[ca_a];
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[ls_wa] <= ls_wd;
    end
    ls_rd_r <= ls_mem[la_a];
  end

  // ---------------------------------------------------------------------------
  // Stage C: sliding window of column sums
  // ---------------------------------------------------------------------------
  logic                c_vld_r;
  logic [3*CSW-1:0]    c_cs_r;
  stg_t                c_stg_r;
  logic [3*CSW-1:0]    wc_r [WIN_MAX];
  logic [3*WSUM_W-1:0] ws_r;
  logic [3*CSW-1:0]    oldc;
  logic [3*WSUM_W-1:0] ws_nxt;
  logic [WSW-1:0]      wc_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      c_cs_r  <= cs_b;
      c_stg_r <= b_stg_r;
    end
  end

  assign wc_idx = WSW'(c_stg_r.wslot);
  assign oldc   = c_stg_r.ltn ? '0 : wc_r[wc_idx];

  always_comb begin
    ws_nxt = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ws_nxt[ch*WSUM_W +: WSUM_W] = c_stg_r.col0 ? WSUM_W'(c_cs_r[ch*CSW +: CSW]) :
          ws_r[ch*WSUM_W +: WSUM_W] + WSUM_W'(c_cs_r[ch*CSW +: CSW]) -
          WSUM_W'(oldc[ch*CSW +: CSW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= '0;
      for (int i = 0; i < WIN_MAX; i++) begin
        wc_r[i] <= '0;
      end
    end else if (c_vld_r) begin
      ws_r         <= ws_nxt;
      wc_r[wc_idx] <= c_cs_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: register window sum; stage E: scale by reciprocal
  // ---------------------------------------------------------------------------
  logic                       d_vld_r;
  logic [3*WSUM_W-1:0]        d_sum_r;
  logic                       d_eol_r;
  logic                       d_eof_r;
  logic                       e_vld_r;
  logic [bbr_pkg::PRD_W-1:0]  e_prd_r [3];
  logic                       e_eol_r;
  logic                       e_eof_r;
  logic [3*PW-1:0]            mean_e;
  bbr_pkg::bbr_res_t          res_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r && c_stg_r.prod;
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      d_sum_r <= ws_nxt;
      d_eol_r <= c_stg_r.eol;
      d_eof_r <= c_stg_r.eof;
    end
    if (d_vld_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        e_prd_r[ch] <= bbr_pkg::PRD_W'(d_sum_r[ch*WSUM_W +: WSUM_W]) *
                       bbr_pkg::PRD_W'(recip_r);
      end
      e_eol_r <= d_eol_r;
      e_eof_r <= d_eof_r;
    end
  end

  // Round half up, drop 16 fraction bits, saturate at full scale
  always_comb begin
    logic [bbr_pkg::PRD_W:0]    rnd;
    logic [bbr_pkg::PRD_W-16:0] m;
    mean_e = '0;
    for (int ch = 0; ch < 3; ch++) begin
      rnd = (bbr_pkg::PRD_W + 1)'(e_prd_r[ch]) + (bbr_pkg::PRD_W + 1)'(32768);
      m   = rnd[bbr_pkg::PRD_W:16];
      mean_e[ch*PW +: PW] = (m > (bbr_pkg::PRD_W - 15)'(255)) ? PW'(255) : m[PW-1:0];
    end
  end

  assign res_e.red   = mean_e[0 +: PW];
  assign res_e.green = mean_e[PW +: PW];
  assign res_e.blue  = mean_e[2*PW +: PW];
  assign res_e.eol   = e_eol_r;
  assign res_e.eof   = e_eof_r;

  // ---------------------------------------------------------------------------
  // Output queue and its credit count
  // ---------------------------------------------------------------------------
  logic              fifo_full;
  logic              pop;
  bbr_pkg::bbr_res_t res_q;

  bbr_fifo #(
    .DEPTH (bbr_pkg::OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (e_vld_r),
    .wdata     (res_e),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (res_q)
  );

  assign pop = out_valid && out_ready;

  // Count producing transactions accepted and not yet taken downstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + CRD_W'(acc && prod_a) - CRD_W'(pop);
    end
  end

  assign out_red          = res_q.red;
  assign out_green        = res_q.green;
  assign out_blue         = res_q.blue;
  assign out_end_of_line  = res_q.eol;
  assign out_end_of_frame = res_q.eof;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    e_vld_r |-> !fifo_full)
    else $error("result pushed into a full output queue");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRD_W'(bbr_pkg::OUT_DEPTH))
    else $error("output credit count overran the queue depth");

  a_credit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (credit_r == '0) |-> !out_valid)
    else $error("output valid with no outstanding transaction");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!rem_st.busy && !clr_busy_r) |-> (slot_r < n_e) && (wslot_r < n_e))
    else $error("line or window slot outside the current window");

  a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> (col_r == '0) && (row_r == '0))
    else $error("raster position moved during the clearing sweep");

endmodule

// ===== test/box_blur_rgb_test.sv =====
module box_blur_rgb_test;

  localparam int MAX_R         = bbr_pkg::MAX_RADIUS_DEF;
  localparam int MAX_W         = bbr_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H         = bbr_pkg::MAX_HEIGHT;
  localparam int PIX_W         = bbr_pkg::PIX_W;
  localparam int CNT_W         = bbr_pkg::CNT_W;
  localparam int RAD_W         = bbr_pkg::RAD_W;
  localparam int RCP_W         = bbr_pkg::RCP_W;
  localparam int CS_W          = bbr_pkg::CS_W;
  localparam int WS_W          = bbr_pkg::WS_W;
  localparam int CFG_W         = bbr_pkg::CFG_W;
  localparam int REG_IDX_W     = bbr_pkg::REG_IDX_W;
  localparam int WIN_CAP       = 2 * MAX_R + 1;
  // Give items without a result room to leave the pipe
  localparam int SETTLE_CYCLES = 16;
  // Longest quiet stretch is the post-reset clearing sweep
  localparam int QUIET_LIMIT   = 100000;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_red    = '0;
  logic [PIX_W-1:0]     in_green  = '0;
  logic [PIX_W-1:0]     in_blue   = '0;
  logic                 in_is_pad = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic                 out_end_of_line;
  logic                 out_end_of_frame;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = bbr_pkg::REG_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  box_blur_rgb uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_is_pad        (in_is_pad),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Blur model state: registers as written, the line store of the last 2r+1
  // rows, per-column sums, the last 2r+1 column sums and the window sums.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   cfg_w, cfg_h;
  logic [RAD_W-1:0]   cfg_r;
  logic [RCP_W-1:0]   cfg_recip;
  logic [3*PIX_W-1:0] row_mem   [WIN_CAP*MAX_W];
  logic [CS_W-1:0]    col_sum_m [3][MAX_W];
  logic [CS_W-1:0]    win_col_m [3][WIN_CAP];
  logic [WS_W-1:0]    win_sum_m [3];
  int unsigned        col_pos, row_pos;
  bbr_pkg::bbr_res_t  blur_expect_q[$];

  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int mismatches     = 0;
  int results_checked = 0;
  int items_sent     = 0;
  int frames_done    = 0;
  int settings_applied = 0;
  int quiet_cycles   = 0;

  // Clamp the registers the way the block reads them
  function automatic void eff_dims(output int unsigned w, h, r);
    w = (cfg_w == 0) ? 1 : (cfg_w > MAX_W) ? MAX_W : cfg_w;
    h = (cfg_h == 0) ? 1 : (cfg_h > MAX_H) ? MAX_H : cfg_h;
    r = (cfg_r > MAX_R) ? MAX_R : cfg_r;
  endfunction

  // Step the raster position; a row ends at the last flush column, or at once
  // if the counter already ran past it after a resize
  function automatic void next_pos(inout int unsigned c, rw, input int unsigned w, h, r);
    if (c >= w + r - 1) begin
      c  = 0;
      rw = (rw >= h + r - 1) ? 0 : (rw + 1) & ((1 << CNT_W) - 1);
    end else begin
      c = (c + 1) & ((1 << CNT_W) - 1);
    end
  endfunction

  function automatic int unsigned recip_for(int unsigned r);
    int unsigned n, v;
    n = (r > MAX_R) ? 2 * MAX_R + 1 : 2 * r + 1;
    v = (65536 + n * n / 2) / (n * n);
    return (v > 65535) ? 65535 : v;
  endfunction

  // Rounded mean in Q16, saturated to a pixel
  function automatic logic [PIX_W-1:0] blur_mean(logic [WS_W-1:0] sum);
    longint unsigned m;
    m = sum;
    m = (m * cfg_recip + 64'd32768) >> 16;
    return (m > 255) ? 8'hFF : m[PIX_W-1:0];
  endfunction

  // Fold one accepted pixel into the sums and queue the blurred pixel it
  // completes, if any
  task automatic blur_predict(input logic [PIX_W-1:0] rv, gv, bv, input logic pad);
    int unsigned w, h, r, n, col, row, slot, idx, old_px, oldc;
    int ch;
    logic [PIX_W-1:0]  px [3];
    logic [CS_W-1:0]   cs;
    logic              in_img;
    bbr_pkg::bbr_res_t res;
    eff_dims(w, h, r);
    n      = 2 * r + 1;
    col    = col_pos;
    row    = row_pos;
    // Pads and anything beyond the image count as black
    in_img = !pad && col < w && row < h;
    px[0]  = in_img ? rv : '0;
    px[1]  = in_img ? gv : '0;
    px[2]  = in_img ? bv : '0;
    slot   = col % n;
    idx    = (row % n) * MAX_W + col;
    for (ch = 0; ch < 3; ch++) begin
      cs = '0;
      if (col < w) begin
        // Rows of an earlier frame never leave the window
        old_px = (row < n) ? 0 : row_mem[idx][PIX_W*ch +: PIX_W];
        if (row == 0) cs = px[ch];
        else cs = col_sum_m[ch][col] + px[ch] - old_px;
        col_sum_m[ch][col] = cs;
      end
      oldc = (col < n) ? 0 : win_col_m[ch][slot];
      if (col == 0) win_sum_m[ch] = cs;
      else win_sum_m[ch] = win_sum_m[ch] + cs - oldc;
      win_col_m[ch][slot] = cs;
    end
    if (col < w) row_mem[idx] = {px[2], px[1], px[0]};
    if (col >= r && row >= r && col - r < w && row - r < h) begin
      res.red   = blur_mean(win_sum_m[0]);
      res.green = blur_mean(win_sum_m[1]);
      res.blue  = blur_mean(win_sum_m[2]);
      res.eol   = (col - r == w - 1);
      res.eof   = res.eol && (row - r == h - 1);
      blur_expect_q.push_back(res);
    end
    next_pos(col_pos, row_pos, w, h, r);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on each pixel transaction, check
  // each blurred pixel in order. Also run the watchdog on quiet cycles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int i, ch;
    bbr_pkg::bbr_res_t want;
    if (!rst_n) begin
      cfg_w     = bbr_pkg::RST_WIDTH;
      cfg_h     = bbr_pkg::RST_HEIGHT;
      cfg_r     = bbr_pkg::RST_RADIUS;
      cfg_recip = bbr_pkg::RST_RECIP;
      col_pos   = 0;
      row_pos   = 0;
      for (i = 0; i < WIN_CAP * MAX_W; i++) row_mem[i] = '0;
      for (ch = 0; ch < 3; ch++) begin
        win_sum_m[ch] = '0;
        for (i = 0; i < MAX_W; i++) col_sum_m[ch][i] = '0;
        for (i = 0; i < WIN_CAP; i++) win_col_m[ch][i] = '0;
      end
      blur_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (bbr_pkg::bbr_reg_t'(cfg_index))
          bbr_pkg::REG_WIDTH:  cfg_w     = cfg_data[CNT_W-1:0];
          bbr_pkg::REG_HEIGHT: cfg_h     = cfg_data[CNT_W-1:0];
          bbr_pkg::REG_RADIUS: cfg_r     = cfg_data[RAD_W-1:0];
          bbr_pkg::REG_RECIP:  cfg_recip = cfg_data[RCP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) blur_predict(in_red, in_green, in_blue, in_is_pad);
      if (out_valid && out_ready) begin
        if (blur_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: blurred pixel %0d/%0d/%0d eol=%0b eof=%0b with nothing expected",
                   $time, out_red, out_green, out_blue, out_end_of_line, out_end_of_frame);
        end else begin
          want = blur_expect_q.pop_front();
          results_checked++;
          if (want.red != out_red || want.green != out_green || want.blue != out_blue ||
              want.eol != out_end_of_line || want.eof != out_end_of_frame) begin
            mismatches++;
            $display("%0t: blurred pixel expected %0d/%0d/%0d eol=%0b eof=%0b,",
                     $time, want.red, want.green, want.blue, want.eol, want.eof,
                     " got %0d/%0d/%0d eol=%0b eof=%0b",
                     out_red, out_green, out_blue, out_end_of_line, out_end_of_frame);
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d blurred pixels still expected",
               $time, quiet_cycles, blur_expect_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off entirely while hold_left runs down
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one pixel; hold it until taken. Gaps drop valid before the offer.
  task automatic send_pixel(input logic [PIX_W-1:0] rv, gv, bv, input logic pad);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_red    <= rv;
    in_green  <= gv;
    in_blue   <= bv;
    in_is_pad <= pad;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid, drain every expected pixel, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    // wait so the monitor has taken the last accepted pixel
    @(posedge clk);
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; junk goes into the bits above the register's width
  task automatic write_reg(bbr_pkg::bbr_reg_t idx, int bits, int unsigned value);
    int unsigned keep;
    keep = (32'd1 << bits) - 1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(($urandom & ~keep) | (value & keep));
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram all registers with the block idle
  task automatic apply_config(int unsigned w, h, r, recip);
    settle();
    write_reg(bbr_pkg::REG_WIDTH, CNT_W, w);
    write_reg(bbr_pkg::REG_HEIGHT, CNT_W, h);
    write_reg(bbr_pkg::REG_RADIUS, RAD_W, r);
    write_reg(bbr_pkg::REG_RECIP, RCP_W, recip);
    cfg_valid <= 1'b0;
    // Wait so the model has taken the last write
    @(posedge clk);
    settings_applied++;
  endtask

  // Send the rest of the current frame, flush border included; a full frame
  // when the raster sits at its origin. Stop early after stop_after pixels.
  // Right after a whole frame the caller passes from_origin, since the model
  // may not have stepped past the last pixel yet.
  task automatic send_frame(int stop_after, bit from_origin = 1'b0);
    int unsigned w, h, r, c, rw;
    int          sent;
    logic        extreme, in_img, pad;
    logic [PIX_W-1:0] p [3];
    int          k;
    eff_dims(w, h, r);
    c       = from_origin ? 0 : col_pos;
    rw      = from_origin ? 0 : row_pos;
    sent    = 0;
    extreme = ($urandom_range(3) == 0);
    do begin
      in_img = (c < w) && (rw < h);
      for (k = 0; k < 3; k++)
        p[k] = extreme ? ($urandom_range(1) ? 8'hFF : 8'h00) : PIX_W'($urandom_range(255));
      // Mostly real pixels inside, mostly pads outside; the rest is noise
      pad = in_img ? ($urandom_range(19) == 0) : ($urandom_range(3) != 0);
      send_pixel(p[0], p[1], p[2], pad);
      sent++;
      next_pos(c, rw, w, h, r);
    end while ((c != 0 || rw != 0) && sent != stop_after);
    if (c == 0 && rw == 0) frames_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Run a few pixels at the reset settings, then shrink the image mid-frame
  // so the column counter sits past the new row end
  task automatic test_reset_and_resize();
    int k;
    for (k = 0; k < 6; k++)
      send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'($urandom_range(1)));
    apply_config(3, 2, 1, recip_for(1));
    send_frame(-1);
  endtask

  task automatic test_directed_corners();
    int k;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    // 1x1 window at full-scale reciprocal: the pixel passes through
    apply_config(1, 1, 0, 65535);
    send_pixel(8'hFF, 8'h00, 8'h80, 1'b0);
    // pad inside the image reads as black
    send_pixel(8'h00, 8'hFF, 8'h01, 1'b1);
    // zero width and height act as one; flush pixels carry live-looking data
    apply_config(0, 0, 1, recip_for(1));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    // 2x2 image, radius 1: every window touches the border
    apply_config(2, 2, 1, recip_for(1));
    for (k = 0; k < 9; k++)
      send_pixel(8'hFF, PIX_W'(k * 31), PIX_W'(255 - k), (k == 3) || (k == 7));
    // zero reciprocal blanks everything
    apply_config(3, 1, 0, 0);
    for (k = 0; k < 3; k++) send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
  endtask

  // Width past the limit clamps to it and radius past ten clamps too; height
  // past the limit only gets its first rows, so the next settings land
  // mid-frame
  task automatic test_size_limits();
    apply_config(2047, 0, 0, 65535);
    send_frame(-1);
    apply_config(1, 1, 15, recip_for(15));
    send_frame(-1);
    apply_config(0, 2047, 0, 65535);
    send_frame(48);
  endtask

  // Random small frames under random settings; some frames are cut short so
  // the next settings land mid-frame
  task automatic test_random_frames(int src_pct, int snk_pct, int budget);
    int          goal, pick;
    int unsigned w, h, r, recip;
    src_gap_pct    = src_pct;
    sink_stall_pct = snk_pct;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      pick  = $urandom_range(19);
      r     = (pick < 14) ? $urandom_range(3) :
              (pick < 19) ? $urandom_range(4, 10) : $urandom_range(11, 15);
      pick  = $urandom_range(19);
      w     = (pick == 0) ? 0 :
              (pick == 1 && r < 4) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      pick  = $urandom_range(19);
      h     = (pick == 0) ? 0 : $urandom_range(1, 8);
      pick  = $urandom_range(9);
      recip = (pick == 0) ? $urandom_range(65535) : (pick == 1) ? 65535 : recip_for(r);
      apply_config(w, h, r, recip);
      // finish a frame left open, now under the new settings
      if (col_pos != 0 || row_pos != 0) send_frame(-1);
      // the raster sits at its origin here either way
      send_frame(($urandom_range(7) == 0) ? $urandom_range(1, 30) : -1, 1'b1);
    end
  endtask

  // Hold the receiver off long enough for the output queue to fill and stall
  // the input while the sender keeps offering
  task automatic test_output_stall();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    apply_config(8, 6, 1, recip_for(1));
    hold_left = 300;
    send_frame(-1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_and_resize();
    test_directed_corners();
    test_size_limits();
    test_random_frames(37, 83, 80);
    test_random_frames(83, 37, 80);
    test_random_frames(0, 0, 80);
    test_output_stall();
    settle();
    $display("Blur run: %0d pixel transactions in %0d whole frames, %0d register settings,",
             items_sent, frames_done, settings_applied);
    $display("  %0d blurred pixels checked, %0d mismatches; stalls on both sides.",
             results_checked, mismatches);
    if (mismatches == 0 && blur_expect_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bbr_pkg.sv
hdl/bbr_rem.sv
hdl/bbr_fifo.sv
hdl/box_blur_rgb.sv
test/box_blur_rgb_test.sv
